>>> sv/mcal_pkg.sv
// shared types, constants and tables of the month calendar grid generator
package mcal_pkg;

    // word layout widths
    localparam int YearW     = 14;
    localparam int MonthW    = 4;
    localparam int DayW      = 5;
    localparam int ColW      = 3;
    localparam int RowW      = 3;
    localparam int PixW      = 11;
    localparam int MarginW   = 9;
    localparam int PitchW    = 8;
    localparam int CfgIdxW   = 2;
    localparam int InDataW   = 24;
    localparam int OutDataW  = 40;
    localparam int OutUserW  = 2;

    // internal arithmetic widths
    localparam int BaseW     = 15;
    localparam int Q100W     = 8;
    localparam int Q7W       = 12;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_LEFT_MARGIN  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TOP_MARGIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_COLUMN_PITCH = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_ROW_PITCH    = 2'd3;

    // configuration reset values
    localparam logic [MarginW-1:0] LEFT_MARGIN_RST  = 9'd20;
    localparam logic [MarginW-1:0] TOP_MARGIN_RST   = 9'd45;
    localparam logic [PitchW-1:0]  COLUMN_PITCH_RST = 8'd45;
    localparam logic [PitchW-1:0]  ROW_PITCH_RST    = 8'd22;

    // year offset that keeps the weekday sum positive
    localparam logic [BaseW-1:0] YEAR_OFFSET = 15'd400;

    // reciprocal multipliers: x/100 = (x*5243)>>19, x/7 = (x*18725)>>17, exact in range
    localparam logic [12:0] RECIP100     = 13'd5243;
    localparam int          RECIP100_SH  = 19;
    localparam logic [14:0] RECIP7       = 15'd18725;
    localparam int          RECIP7_SH    = 17;

    localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
    localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
    localparam logic [MonthW-1:0] MONTH_MAR = 4'd3;
    localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;
    localparam logic [MonthW-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DayW-1:0]   LEAP_FEB_DAYS   = 5'd29;
    localparam logic [ColW-1:0]   COL_SUNDAY      = 3'd0;
    localparam logic [ColW-1:0]   COL_SATURDAY    = 3'd6;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // latch the incoming word
        logic div_step;   // divide year by 100
        logic sum_step;   // leap year, month length, weekday sum
        logic mul_step;   // quotient of the sum by 7
        logic rem_step;   // remainder gives column of the 1st
        logic load_cell;  // move the next cell into the output register
    } mcal_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic new_month;  // incoming date differs and month is valid
        logic out_free;   // output register can take a cell
        logic last_day;   // current cell is the last of the month
    } mcal_status_t;

    // days per month, february without leap day
    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
        logic [DayW-1:0] d;
        unique case (m)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // (13*m + 8) / 5 for shifted month 3..14
    function automatic logic [5:0] month_term(input logic [MonthW-1:0] mm);
        logic [5:0] t;
        unique case (mm)
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            4'd13:   t = 6'd35;
            4'd14:   t = 6'd38;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

>>> sv/month_calendar_grid_generator_top.sv
// top level of the month calendar grid generator
//
//   channel   direction   handshake            payload
//   s_        in          s_tvalid/s_tready    s_tdata: year, month, today
//   m_        out         m_tvalid/m_tready    m_tdata: cell, m_tuser: flags, m_tlast
//   cfg_      in          cfg_wr_en            cfg_index, cfg_wdata
//
// a new date is accepted and then set up in order (year/100 multiply, leap and
// weekday sum, divide by 7 multiply, remainder), then one cell per cycle while m_tready
// does not stall the output, 28 to 31 cells per date
// a repeated date or a month outside 1..12 is accepted and emits nothing
// a stalled m_tready holds the output register and the cell counters
// s_tready is high only while no month is being set up or emitted
// reset (aresetn low, synchronous) restores the default margins and pitches
module month_calendar_grid_generator_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input word
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mcal_pkg::InDataW-1:0]          s_tdata,   // year[13:0], month[17:14], today[22:18]
    // result word
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mcal_pkg::OutDataW-1:0]         m_tdata,   // day_number[4:0], column[7:5],
                                                             // row[10:8], pixel_x[21:11], pixel_y[32:22]
    output logic [mcal_pkg::OutUserW-1:0]         m_tuser,   // is_weekend[0], is_today[1]
    output logic                                  m_tlast,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [mcal_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [mcal_pkg::MarginW-1:0]          cfg_wdata
);

    mcal_pkg::mcal_cmd_t    cmd;
    mcal_pkg::mcal_status_t status;

    mcal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mcal_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_year   (s_tdata[13:0]),
        .in_month  (s_tdata[17:14]),
        .in_today  (s_tdata[22:18]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

    // a cell is never loaded over one still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_cell |-> (!m_tvalid || m_tready))
        else $error("cell loaded over a pending output word");

    // no new date is taken while cells are still being produced
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.load_cell)
        else $error("input open while emitting cells");

    // at most one sequencing step per cycle
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.div_step, cmd.sum_step, cmd.mul_step, cmd.rem_step, cmd.load_cell}))
        else $error("overlapping datapath steps");

    // the last cell of a month reopens the input once it is loaded
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_cell && status.last_day) |=> s_tready)
        else $error("input not reopened after the last cell");

endmodule

>>> sv/mcal_ctrl.sv
// controller state machine sequencing weekday setup and cell emission
module mcal_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mcal_pkg::mcal_status_t status,
    output mcal_pkg::mcal_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_MUL,
        ST_REM,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // command decode
    always_comb begin
        cmd           = '0;
        s_tready      = (state_reg == ST_IDLE);
        cmd.accept    = s_tvalid && s_tready;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.sum_step  = (state_reg == ST_SUM);
        cmd.mul_step  = (state_reg == ST_MUL);
        cmd.rem_step  = (state_reg == ST_REM);
        cmd.load_cell = (state_reg == ST_EMIT) && status.out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && status.new_month) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_REM;
            ST_REM:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (cmd.load_cell && status.last_day) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/mcal_dp.sv
// datapath: date store, weekday arithmetic, cell counters and output register
module mcal_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // incoming word fields
    input  logic [mcal_pkg::YearW-1:0]           in_year,
    input  logic [mcal_pkg::MonthW-1:0]          in_month,
    input  logic [mcal_pkg::DayW-1:0]            in_today,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [mcal_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [mcal_pkg::MarginW-1:0]         cfg_wdata,
    // control
    input  mcal_pkg::mcal_cmd_t                  cmd,
    output mcal_pkg::mcal_status_t               status,
    // result word
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [mcal_pkg::OutDataW-1:0]        out_data,
    output logic [mcal_pkg::OutUserW-1:0]        out_user,
    output logic                                 out_last
);

    localparam int BaseW = mcal_pkg::BaseW;
    localparam int DayW  = mcal_pkg::DayW;

    // configuration registers
    logic [mcal_pkg::MarginW-1:0] left_margin_reg;
    logic [mcal_pkg::MarginW-1:0] top_margin_reg;
    logic [mcal_pkg::PitchW-1:0]  column_pitch_reg;
    logic [mcal_pkg::PitchW-1:0]  row_pitch_reg;

    // previous date
    logic [mcal_pkg::YearW-1:0]   prev_year_reg;
    logic [mcal_pkg::MonthW-1:0]  prev_month_reg;
    logic [DayW-1:0]              prev_day_reg;
    logic                         prev_valid_reg;

    // setup registers
    logic [BaseW-1:0]             base_reg;
    logic                         dec_reg;
    logic [mcal_pkg::MonthW-1:0]  mm_reg;
    logic [mcal_pkg::MonthW-1:0]  mon_reg;
    logic [DayW-1:0]              today_reg;
    logic [mcal_pkg::Q100W-1:0]   q100_reg;
    logic [BaseW-1:0]             sum_reg;
    logic [DayW-1:0]              days_reg;
    logic [mcal_pkg::Q7W-1:0]     q7_reg;

    // cell counters
    logic [DayW-1:0]              day_reg;
    logic [mcal_pkg::ColW-1:0]    col_reg;
    logic [mcal_pkg::RowW-1:0]    row_reg;

    // output register
    logic                         out_valid_reg;
    logic [DayW-1:0]              o_day_reg;
    logic [mcal_pkg::ColW-1:0]    o_col_reg;
    logic [mcal_pkg::RowW-1:0]    o_row_reg;
    logic [mcal_pkg::PixW-1:0]    o_px_reg;
    logic [mcal_pkg::PixW-1:0]    o_py_reg;
    logic                         o_weekend_reg;
    logic                         o_today_reg;
    logic                         o_last_reg;

    logic                         same_date;
    logic                         month_ok;
    logic                         early_month;
    logic [27:0]                  prod100;
    logic [BaseW-1:0]             rem100;
    logic                         zero100;
    logic                         leap;
    logic [BaseW-1:0]             yy;
    logic [mcal_pkg::Q100W-1:0]   qyy;
    logic [BaseW-1:0]             sum_next;
    logic [DayW-1:0]              days_next;
    logic [29:0]                  prod7;
    logic [BaseW-1:0]             rem7;
    logic [mcal_pkg::PixW-1:0]    px_next;
    logic [mcal_pkg::PixW-1:0]    py_next;

    // incoming date checks
    assign same_date   = prev_valid_reg && (in_year == prev_year_reg) &&
                         (in_month == prev_month_reg) && (in_today == prev_day_reg);
    assign month_ok    = (in_month >= mcal_pkg::MONTH_JAN) && (in_month <= mcal_pkg::MONTH_DEC);
    assign early_month = (in_month < mcal_pkg::MONTH_MAR);

    assign status.new_month = !same_date && month_ok;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_day  = (day_reg == days_reg);

    // year divided by 100 through a reciprocal multiply
    assign prod100 = 28'(base_reg) * 28'(mcal_pkg::RECIP100);

    // leap year and weekday sum; january and february count as months 13, 14 of last year
    always_comb begin
        rem100    = base_reg - BaseW'(q100_reg) * BaseW'(100);
        zero100   = (rem100 == '0);
        leap      = ((base_reg[1:0] == 2'b00) && !zero100) ||
                    (zero100 && (q100_reg[1:0] == 2'b00));
        yy        = base_reg - BaseW'(dec_reg);
        qyy       = q100_reg - mcal_pkg::Q100W'(dec_reg && zero100);
        sum_next  = yy + (yy >> 2) - BaseW'(qyy) + BaseW'(qyy >> 2) +
                    BaseW'(mcal_pkg::month_term(mm_reg)) + BaseW'(1);
        days_next = ((mon_reg == mcal_pkg::MONTH_FEB) && leap) ?
                    mcal_pkg::LEAP_FEB_DAYS : mcal_pkg::month_days(mon_reg);
    end

    // weekday sum modulo 7
    assign prod7 = 30'(sum_reg) * 30'(mcal_pkg::RECIP7);
    assign rem7  = sum_reg - BaseW'(q7_reg) * BaseW'(7);

    // pixel positions of the current cell
    assign px_next = mcal_pkg::PixW'(left_margin_reg) +
                     mcal_pkg::PixW'(col_reg) * mcal_pkg::PixW'(column_pitch_reg);
    assign py_next = mcal_pkg::PixW'(top_margin_reg) +
                     mcal_pkg::PixW'(row_reg) * mcal_pkg::PixW'(row_pitch_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_margin_reg  <= mcal_pkg::LEFT_MARGIN_RST;
            top_margin_reg   <= mcal_pkg::TOP_MARGIN_RST;
            column_pitch_reg <= mcal_pkg::COLUMN_PITCH_RST;
            row_pitch_reg    <= mcal_pkg::ROW_PITCH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mcal_pkg::CFG_LEFT_MARGIN:  left_margin_reg  <= cfg_wdata;
                mcal_pkg::CFG_TOP_MARGIN:   top_margin_reg   <= cfg_wdata;
                mcal_pkg::CFG_COLUMN_PITCH: column_pitch_reg <= cfg_wdata[mcal_pkg::PitchW-1:0];
                mcal_pkg::CFG_ROW_PITCH:    row_pitch_reg    <= cfg_wdata[mcal_pkg::PitchW-1:0];
                default: ;
            endcase
        end
    end

    // previous date store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_year_reg  <= '0;
            prev_month_reg <= '0;
            prev_day_reg   <= '0;
            prev_valid_reg <= 1'b0;
        end else if (cmd.accept) begin
            prev_year_reg  <= in_year;
            prev_month_reg <= in_month;
            prev_day_reg   <= in_today;
            prev_valid_reg <= 1'b1;
        end
    end

    // weekday setup steps
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            base_reg  <= BaseW'(in_year) + mcal_pkg::YEAR_OFFSET;
            dec_reg   <= early_month;
            mm_reg    <= early_month ? in_month + mcal_pkg::MONTHS_PER_YEAR : in_month;
            mon_reg   <= in_month;
            today_reg <= in_today;
        end
        if (cmd.div_step) begin
            q100_reg <= prod100[mcal_pkg::RECIP100_SH +: mcal_pkg::Q100W];
        end
        if (cmd.sum_step) begin
            sum_reg  <= sum_next;
            days_reg <= days_next;
        end
        if (cmd.mul_step) begin
            q7_reg <= prod7[mcal_pkg::RECIP7_SH +: mcal_pkg::Q7W];
        end
    end

    // day, column and row counters
    always_ff @(posedge aclk) begin
        if (cmd.rem_step) begin
            day_reg <= DayW'(1);
            col_reg <= rem7[mcal_pkg::ColW-1:0];
            row_reg <= '0;
        end else if (cmd.load_cell) begin
            day_reg <= day_reg + DayW'(1);
            if (col_reg == mcal_pkg::COL_SATURDAY) begin
                col_reg <= mcal_pkg::COL_SUNDAY;
                row_reg <= row_reg + mcal_pkg::RowW'(1);
            end else begin
                col_reg <= col_reg + mcal_pkg::ColW'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_cell) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.load_cell) begin
            o_day_reg     <= day_reg;
            o_col_reg     <= col_reg;
            o_row_reg     <= row_reg;
            o_px_reg      <= px_next;
            o_py_reg      <= py_next;
            o_weekend_reg <= (col_reg == mcal_pkg::COL_SUNDAY) ||
                             (col_reg == mcal_pkg::COL_SATURDAY);
            o_today_reg   <= (day_reg == today_reg);
            o_last_reg    <= (day_reg == days_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'd0, o_py_reg, o_px_reg, o_row_reg, o_col_reg, o_day_reg};
    assign out_user  = {o_today_reg, o_weekend_reg};
    assign out_last  = o_last_reg;

endmodule
